>>> hdl/dwp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwp_pkg
// Shared types and codes of the module word parser.
// ----------------------------------------------------------------------------
package dwp_pkg;

    localparam int DEFAULT_MAX_MODULES = 8;
    localparam int TABLE_W             = 64;
    localparam int MASK_W              = 8;
    localparam int COUNT_W             = 4;
    localparam int CHAN_SLOTS          = 34;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [1:0] TOP_SHORT  = 2'b00;
    localparam logic [1:0] TOP_HEADER = 2'b01;
    localparam logic [1:0] TOP_FOOTER = 2'b11;

    localparam logic [7:0] SUB_DUMMY = 8'h00;
    localparam logic [7:0] SUB_DATA  = 8'h10;
    localparam logic [7:0] SUB_EXT   = 8'h12;

    localparam logic [5:0] MAX_CHANNEL = 6'd33;

    localparam logic [1:0] CFG_ID_TABLE = 2'd0;
    localparam logic [1:0] CFG_QDC_MASK = 2'd1;
    localparam logic [1:0] CFG_IN_USE   = 2'd2;

    typedef enum logic [2:0] {
        CLS_HEADER,
        CLS_DATA,
        CLS_EXT,
        CLS_FOOTER,
        CLS_DUMMY,
        CLS_ILLEGAL
    } cls_t;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_DATA    = 3'd1,
        KIND_EXT     = 3'd2,
        KIND_FOOTER  = 3'd3,
        KIND_DUMMY   = 3'd4,
        KIND_ILLEGAL = 3'd5,
        KIND_SKIPPED = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_UNKNOWN_ID = 3'd1,
        ERR_NO_EVENT   = 3'd2,
        ERR_REPEAT_CH  = 3'd3,
        ERR_CH_RANGE   = 3'd4,
        ERR_ILLEGAL    = 3'd5
    } err_t;

    typedef struct packed {
        logic [31:0] word;
        logic        block_start;
        cls_t        cls;
        logic        id_hit;
        logic [2:0]  id_index;
    } mid_item_t;

    typedef struct packed {
        kind_t       kind;
        err_t        error_code;
        logic [2:0]  module_index;
        logic [5:0]  channel;
        logic [31:0] raw_word;
        logic [31:0] event_seq;
        logic [11:0] event_length;
        logic [45:0] timestamp;
    } res_t;

    localparam int MID_W = $bits(mid_item_t);
    localparam int RES_W = $bits(res_t);

endpackage

>>> hdl/dwp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwp_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module dwp_fifo
    import dwp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wp_reg;
    logic [AW-1:0]    rp_reg;
    logic [CW-1:0]    cnt_reg;

    logic do_wr;
    logic do_rd;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rp_reg];

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= ptr_inc(wp_reg);
            end
            if (do_rd)
            begin
                rp_reg <= ptr_inc(rp_reg);
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

>>> hdl/dwp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwp_front
// Word classifier and module id lookup.
// ----------------------------------------------------------------------------
module dwp_front
    import dwp_pkg::*;
#(
    parameter int MAX_MODULES = DEFAULT_MAX_MODULES
)
(
    input  logic [31:0]        word,
    input  logic               block_start,
    input  logic [TABLE_W-1:0] id_table,
    input  logic [COUNT_W-1:0] in_use,
    output mid_item_t          item
);

    localparam logic [COUNT_W-1:0] MaxCnt = COUNT_W'(MAX_MODULES);

    logic [COUNT_W-1:0] search_n;
    logic [7:0]         hdr_id;
    logic [7:0]         sub;
    logic               hit;
    logic [2:0]         idx;
    cls_t               cls;

    assign search_n = (in_use > MaxCnt) ? MaxCnt : in_use;
    assign hdr_id   = word[23:16];
    assign sub      = word[29:22];

    // lowest matching entry wins
    always_comb
    begin
        hit = 1'b0;
        idx = '0;
        for (int k = MAX_MODULES - 1; k >= 0; k--)
        begin
            if ((COUNT_W'(k) < search_n) && (id_table[8*k +: 8] == hdr_id))
            begin
                hit = 1'b1;
                idx = 3'(k);
            end
        end
    end

    always_comb
    begin
        case (word[31:30])
            TOP_HEADER: cls = CLS_HEADER;
            TOP_FOOTER: cls = CLS_FOOTER;
            TOP_SHORT:
            begin
                case (sub)
                    SUB_DUMMY: cls = CLS_DUMMY;
                    SUB_DATA:  cls = CLS_DATA;
                    SUB_EXT:   cls = CLS_EXT;
                    default:   cls = CLS_ILLEGAL;
                endcase
            end
            default:    cls = CLS_ILLEGAL;
        endcase
    end

    always_comb
    begin
        item.word        = word;
        item.block_start = block_start;
        item.cls         = cls;
        item.id_hit      = hit;
        item.id_index    = idx;
    end

endmodule

>>> hdl/dwp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwp_back
// Event state, channel record and per-module event counters.
// ----------------------------------------------------------------------------
module dwp_back
    import dwp_pkg::*;
#(
    parameter int MAX_MODULES = DEFAULT_MAX_MODULES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  mid_item_t         in_item,
    output logic              in_taken,
    input  logic [MASK_W-1:0] qdc_mask,
    input  logic              out_full,
    output logic              out_wr,
    output res_t              out_res
);

    localparam int CNT_AW = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;

    logic                  event_open_reg, event_open_next;
    logic [2:0]            cur_module_reg, cur_module_next;
    logic [CHAN_SLOTS-1:0] filled_reg, filled_next;
    logic [15:0]           ext_val_reg, ext_val_next;
    logic                  ext_pres_reg, ext_pres_next;
    logic                  skip_reg, skip_next;
    logic [31:0]           cnt_reg [MAX_MODULES];

    logic        fire;
    logic        open_now;
    logic        skip_now;
    logic        cnt_inc;
    logic [31:0] cnt_plus;
    logic [4:0]  c5;
    logic [5:0]  c6;
    res_t        res;

    assign fire     = in_valid && !out_full;
    assign in_taken = fire;
    assign out_wr   = fire;
    assign out_res  = res;

    // block start clears the open event and skipping before decoding
    assign open_now = in_item.block_start ? 1'b0 : event_open_reg;
    assign skip_now = in_item.block_start ? 1'b0 : skip_reg;
    assign cnt_plus = cnt_reg[in_item.id_index[CNT_AW-1:0]] + 32'd1;
    assign c5       = in_item.word[20:16];
    assign c6       = in_item.word[21:16];

    always_comb
    begin
        event_open_next = open_now;
        skip_next       = skip_now;
        cur_module_next = cur_module_reg;
        filled_next     = filled_reg;
        ext_val_next    = ext_val_reg;
        ext_pres_next   = ext_pres_reg;
        cnt_inc         = 1'b0;

        res              = '0;
        res.kind         = KIND_SKIPPED;
        res.error_code   = ERR_NONE;
        res.raw_word     = in_item.word;

        if (!skip_now)
        begin
            case (in_item.cls)
                CLS_HEADER:
                begin
                    res.kind = KIND_HEADER;
                    if (!in_item.id_hit)
                    begin
                        res.error_code  = ERR_UNKNOWN_ID;
                        skip_next       = 1'b1;
                        event_open_next = 1'b0;
                    end
                    else
                    begin
                        cur_module_next  = in_item.id_index;
                        event_open_next  = 1'b1;
                        filled_next      = '0;
                        ext_val_next     = '0;
                        ext_pres_next    = 1'b0;
                        cnt_inc          = 1'b1;
                        res.module_index = in_item.id_index;
                        res.event_seq    = cnt_plus;
                        res.event_length = in_item.word[11:0];
                    end
                end
                CLS_DATA:
                begin
                    res.kind = KIND_DATA;
                    if (!open_now)
                    begin
                        res.error_code  = ERR_NO_EVENT;
                        skip_next       = 1'b1;
                        event_open_next = 1'b0;
                    end
                    else
                    begin
                        res.module_index = cur_module_reg;
                        if (qdc_mask[cur_module_reg])
                        begin
                            res.channel = {1'b0, c5};
                            if (filled_reg[{1'b0, c5}])
                            begin
                                res.error_code  = ERR_REPEAT_CH;
                                skip_next       = 1'b1;
                                event_open_next = 1'b0;
                            end
                            else
                            begin
                                filled_next[{1'b0, c5}] = 1'b1;
                            end
                        end
                        else
                        begin
                            res.channel = c6;
                            if (c6 > MAX_CHANNEL)
                            begin
                                res.error_code  = ERR_CH_RANGE;
                                skip_next       = 1'b1;
                                event_open_next = 1'b0;
                            end
                            else
                            begin
                                filled_next[c6] = 1'b1;
                            end
                        end
                    end
                end
                CLS_EXT:
                begin
                    res.kind = KIND_EXT;
                    if (!open_now)
                    begin
                        res.error_code  = ERR_NO_EVENT;
                        skip_next       = 1'b1;
                        event_open_next = 1'b0;
                    end
                    else
                    begin
                        res.module_index = cur_module_reg;
                        ext_val_next     = in_item.word[15:0];
                        ext_pres_next    = 1'b1;
                    end
                end
                CLS_FOOTER:
                begin
                    res.kind = KIND_FOOTER;
                    if (!open_now)
                    begin
                        res.error_code  = ERR_NO_EVENT;
                        skip_next       = 1'b1;
                        event_open_next = 1'b0;
                    end
                    else
                    begin
                        res.module_index = cur_module_reg;
                        res.timestamp    = {ext_pres_reg ? ext_val_reg : 16'h0,
                                            in_item.word[29:0]};
                        event_open_next  = 1'b0;
                    end
                end
                CLS_DUMMY:
                begin
                    res.kind = KIND_DUMMY;
                end
                default:
                begin
                    res.kind       = KIND_ILLEGAL;
                    res.error_code = ERR_ILLEGAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_open_reg <= 1'b0;
            cur_module_reg <= '0;
            filled_reg     <= '0;
            ext_val_reg    <= '0;
            ext_pres_reg   <= 1'b0;
            skip_reg       <= 1'b0;
            for (int k = 0; k < MAX_MODULES; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else if (fire)
        begin
            event_open_reg <= event_open_next;
            cur_module_reg <= cur_module_next;
            filled_reg     <= filled_next;
            ext_val_reg    <= ext_val_next;
            ext_pres_reg   <= ext_pres_next;
            skip_reg       <= skip_next;
            if (cnt_inc)
            begin
                cnt_reg[in_item.id_index[CNT_AW-1:0]] <= cnt_plus;
            end
        end
    end

    a_skip_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fire && skip_reg && !in_item.block_start |=> skip_reg)
        else $error("skip state left without block start");

    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.kind == KIND_SKIPPED |->
            res.error_code == ERR_NONE && res.timestamp == '0 && res.event_seq == '0)
        else $error("skipped word carries result fields");

    a_footer_closes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.kind == KIND_FOOTER && res.error_code == ERR_NONE |=> !event_open_reg)
        else $error("event still open after footer");

    a_error_skips: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.error_code != ERR_NONE && res.error_code != ERR_ILLEGAL
            |=> skip_reg && !event_open_reg)
        else $error("error did not start skipping");

endmodule

>>> hdl/daq_module_word_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daq_module_word_parser
// Readout word decoder: classifies module words and tracks open events.
// ----------------------------------------------------------------------------
// Input side is a queue: a word transfers on push while full is low. Results
// come out of a queue: the oldest result is on the ports while empty is low
// and transfers on pop. Configuration is written through cfg_valid/cfg_ready
// (always ready) with cfg_index 0 id table, 1 qdc mask, 2 modules in use;
// write it only while no word is in flight.
// The front classifies the word and looks up the header id against the
// table combinationally and places it in a two-entry queue. The back applies
// one word per cycle, while the result queue is not full, to the event state
// and counters and writes a two-entry result queue. A word is registered in
// the middle queue, then its result in the result queue and on the ports;
// one word per cycle is sustained while pop keeps up, limited by the state
// update in the back. When pop is held low the result queue fills, then the
// middle queue, and full rises after four words are waiting. Reset clears
// the queues, the event state, the event counters and the configuration.
// ----------------------------------------------------------------------------
module daq_module_word_parser
    import dwp_pkg::*;
#(
    parameter int MAX_MODULES = DEFAULT_MAX_MODULES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [31:0]        word,
    input  logic               block_start,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         kind,
    output logic [2:0]         error_code,
    output logic [2:0]         module_index,
    output logic [5:0]         channel,
    output logic [31:0]        raw_word,
    output logic [31:0]        event_seq,
    output logic [11:0]        event_length,
    output logic [45:0]        timestamp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [TABLE_W-1:0] cfg_data
);

    logic [TABLE_W-1:0] id_table_reg;
    logic [MASK_W-1:0]  qdc_mask_reg;
    logic [COUNT_W-1:0] in_use_reg;

    mid_item_t front_item;
    mid_item_t mid_item;
    logic      mid_empty;
    logic      mid_taken;
    logic      res_wr;
    logic      res_full;
    res_t      back_res;
    res_t      out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_table_reg <= '0;
            qdc_mask_reg <= '0;
            in_use_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ID_TABLE: id_table_reg <= cfg_data;
                CFG_QDC_MASK: qdc_mask_reg <= cfg_data[MASK_W-1:0];
                CFG_IN_USE:   in_use_reg   <= cfg_data[COUNT_W-1:0];
                default:      ;
            endcase
        end
    end

    dwp_front #(
        .MAX_MODULES (MAX_MODULES)
    ) u_front (
        .word        (word),
        .block_start (block_start),
        .id_table    (id_table_reg),
        .in_use      (in_use_reg),
        .item        (front_item)
    );

    dwp_fifo #(
        .WIDTH (MID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .wdata (front_item),
        .rd    (mid_taken),
        .rdata (mid_item),
        .full  (full),
        .empty (mid_empty)
    );

    dwp_back #(
        .MAX_MODULES (MAX_MODULES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!mid_empty),
        .in_item  (mid_item),
        .in_taken (mid_taken),
        .qdc_mask (qdc_mask_reg),
        .out_full (res_full),
        .out_wr   (res_wr),
        .out_res  (back_res)
    );

    dwp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_wr),
        .wdata (back_res),
        .rd    (pop),
        .rdata (out_res),
        .full  (res_full),
        .empty (empty)
    );

    assign kind         = out_res.kind;
    assign error_code   = out_res.error_code;
    assign module_index = out_res.module_index;
    assign channel      = out_res.channel;
    assign raw_word     = out_res.raw_word;
    assign event_seq    = out_res.event_seq;
    assign event_length = out_res.event_length;
    assign timestamp    = out_res.timestamp;

endmodule
